FILE: rtl/core/saq_pkg.sv
// ----------------------------------------------------------------------------
// saq_pkg: shared types and constants for the shortest-arc quaternion unit
// Field widths, normalized magnitude format and the per-lane record.
// ----------------------------------------------------------------------------
`default_nettype none

package saq_pkg;

    localparam int DATA_W  = 16;            // every input and output field
    localparam int NLANE   = 4;             // w, x, y, z
    localparam int IN_W    = 6 * DATA_W;    // six packed vector components
    localparam int OUT_W   = NLANE * DATA_W;
    localparam int NMAG_W  = 30;            // magnitudes after prescale are below 2^30
    localparam int SQ_W    = 2 * NMAG_W;
    localparam int SUM_W   = SQ_W + 2;      // sum of four squares
    localparam int ROOT_W  = SUM_W / 2;     // floor sqrt of the sum
    localparam int QUO_W   = 17;            // enough to saturate at 32768

    typedef struct packed {
        logic              neg;
        logic [NMAG_W-1:0] mag;
    } lane_t;

    typedef lane_t [NLANE-1:0] quat_t;

endpackage

`default_nettype wire

FILE: rtl/core/shortest_arc_quaternion_unit.sv
// ----------------------------------------------------------------------------
// shortest_arc_quaternion_unit: rotation quaternion between two unit vectors
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata: first_x,y,z, second_x,y,z
// m_       out  m_tvalid/m_tready    m_tdata: quat_w, quat_x, quat_y, quat_z
//
// One request per cycle while the output is not stalled, fully pipelined. The
// front ends in NSH shift stages (NSH = clog2 of 2*FRAC_BITS-27, at least 35-29),
// the norm runs 31 square-root steps and the divider 17 quotient bits. Reset
// clears only the valid bits. When a result waits on m_tready every stage
// holds; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_arc_quaternion_unit #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  wire logic [saq_pkg::IN_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [saq_pkg::OUT_W-1:0]           m_tdata
);
    import saq_pkg::*;

    logic                     ce;
    logic                     f_valid, r_valid;
    quat_t                    f_quat, r_quat;
    logic [ROOT_W-1:0]        r_root;
    logic [NLANE-1:0]         d_valid;
    logic signed [DATA_W-1:0] d_q [NLANE];

    assign ce       = m_tready || !m_tvalid;
    assign s_tready = ce;
    assign m_tvalid = &d_valid;

    saq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (s_tvalid),
        .ax       (s_tdata[0*DATA_W +: DATA_W]),
        .ay       (s_tdata[1*DATA_W +: DATA_W]),
        .az       (s_tdata[2*DATA_W +: DATA_W]),
        .bx       (s_tdata[3*DATA_W +: DATA_W]),
        .by       (s_tdata[4*DATA_W +: DATA_W]),
        .bz       (s_tdata[5*DATA_W +: DATA_W]),
        .out_valid(f_valid),
        .out_quat (f_quat)
    );

    saq_root u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (f_valid),
        .in_quat  (f_quat),
        .out_valid(r_valid),
        .out_quat (r_quat),
        .out_root (r_root)
    );

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        saq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .in_valid (r_valid),
            .in_lane  (r_quat[l]),
            .in_root  (r_root),
            .out_valid(d_valid[l]),
            .out_q    (d_q[l])
        );
        assign m_tdata[l*DATA_W +: DATA_W] = d_q[l];
    end

endmodule

`default_nettype wire

FILE: rtl/core/saq_front.sv
// ----------------------------------------------------------------------------
// saq_front: raw quaternion and magnitude prescale
// Products, dot/cross sums, opposite-vector axis select, sign/magnitude
// split, then a staged right shift that brings every magnitude below 2^30.
// ----------------------------------------------------------------------------
`default_nettype none

module saq_front #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                ce,
    input  wire logic                                in_valid,
    input  wire logic signed [saq_pkg::DATA_W-1:0]   ax,
    input  wire logic signed [saq_pkg::DATA_W-1:0]   ay,
    input  wire logic signed [saq_pkg::DATA_W-1:0]   az,
    input  wire logic signed [saq_pkg::DATA_W-1:0]   bx,
    input  wire logic signed [saq_pkg::DATA_W-1:0]   by,
    input  wire logic signed [saq_pkg::DATA_W-1:0]   bz,
    output logic                                     out_valid,
    output saq_pkg::quat_t                           out_quat
);
    import saq_pkg::*;

    localparam int PW  = 2 * DATA_W;
    localparam int DW  = PW + 2;
    localparam int QW  = (2 * FRAC_BITS + 2 > 35) ? 2 * FRAC_BITS + 2 : 35;
    localparam int TW  = (FRAC_BITS + 1 > DATA_W + 1) ? FRAC_BITS + 1 : DATA_W + 1;
    localparam int NSH = $clog2(QW - NMAG_W + 1);
    localparam logic [TW-1:0] THRESH =
        TW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic signed [QW-1:0] ONE2     = QW'(1) << (2 * FRAC_BITS);
    localparam logic signed [QW-1:0] NEG_ONE2 = -ONE2;

    // stage 1: products
    logic                 v1_reg;
    logic signed [PW-1:0] p_reg [9];
    logic signed [DATA_W-1:0] a1_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg[0]  <= ax * bx;
            p_reg[1]  <= ay * by;
            p_reg[2]  <= az * bz;
            p_reg[3]  <= ay * bz;
            p_reg[4]  <= az * by;
            p_reg[5]  <= az * bx;
            p_reg[6]  <= ax * bz;
            p_reg[7]  <= ax * by;
            p_reg[8]  <= ay * bx;
            a1_reg[0] <= ax;
            a1_reg[1] <= ay;
            a1_reg[2] <= az;
        end
    end

    // stage 2: dot and cross sums, small-x test
    logic                     v2_reg;
    logic signed [DW-1:0]     d_reg, cx_reg, cy_reg, cz_reg;
    logic signed [DATA_W-1:0] a2_reg [3];
    logic                     small_reg;
    logic signed [DATA_W:0]   axe;
    logic        [DATA_W:0]   ax_abs;

    always_comb begin
        axe    = (DATA_W + 1)'(a1_reg[0]);
        ax_abs = axe[DATA_W] ? -axe : axe;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg     <= DW'(p_reg[0]) + DW'(p_reg[1]) + DW'(p_reg[2]);
            cx_reg    <= DW'(p_reg[3]) - DW'(p_reg[4]);
            cy_reg    <= DW'(p_reg[5]) - DW'(p_reg[6]);
            cz_reg    <= DW'(p_reg[7]) - DW'(p_reg[8]);
            a2_reg    <= a1_reg;
            small_reg <= TW'(ax_abs) < THRESH;
        end
    end

    // stage 3: raw quaternion
    logic                 v3_reg;
    logic signed [QW-1:0] q_reg [NLANE];
    logic signed [QW-1:0] q_next [NLANE];
    logic signed [QW-1:0] axs, ays, azs;
    logic                 opp;

    always_comb begin
        axs = QW'(a2_reg[0]) <<< FRAC_BITS;
        ays = QW'(a2_reg[1]) <<< FRAC_BITS;
        azs = QW'(a2_reg[2]) <<< FRAC_BITS;
        opp = !(QW'(d_reg) > NEG_ONE2);
        if (!opp) begin
            q_next[0] = ONE2 + QW'(d_reg);
            q_next[1] = QW'(cx_reg);
            q_next[2] = QW'(cy_reg);
            q_next[3] = QW'(cz_reg);
        end else if (small_reg) begin
            q_next[0] = '0;
            q_next[1] = '0;
            q_next[2] = azs;
            q_next[3] = -ays;
        end else begin
            q_next[0] = '0;
            q_next[1] = ays;
            q_next[2] = -axs;
            q_next[3] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            q_reg <= q_next;
        end
    end

    // stage 4 and shift stages: index 0 holds sign/magnitude
    logic [NLANE-1:0][QW-1:0] sh_mag_reg [NSH+1];
    logic [NLANE-1:0]         sh_neg_reg [NSH+1];
    logic                     sh_big_reg [NSH+1];
    logic                     sh_v_reg   [NSH+1];
    logic [NLANE-1:0][QW-1:0] mag_next;
    logic [NLANE-1:0]         neg_next;
    logic                     big_next;

    always_comb begin
        big_next = 1'b0;
        for (int l = 0; l < NLANE; l++) begin
            neg_next[l] = q_reg[l][QW-1];
            mag_next[l] = neg_next[l] ? QW'(-q_reg[l]) : QW'(q_reg[l]);
            big_next    = big_next | (|mag_next[l][QW-1:NMAG_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sh_v_reg[0] <= 1'b0;
        end else if (ce) begin
            sh_v_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sh_mag_reg[0] <= mag_next;
            sh_neg_reg[0] <= neg_next;
            sh_big_reg[0] <= big_next;
        end
    end

    // greedy shift: take each power-of-two step that keeps the largest >= 2^29
    for (genvar k = 0; k < NSH; k++) begin : g_shift
        localparam int SH = 1 << (NSH - 1 - k);
        logic [QW-1:0]            orall;
        logic                     take;
        logic [NLANE-1:0][QW-1:0] smag_next;

        always_comb begin
            orall = '0;
            for (int l = 0; l < NLANE; l++) begin
                orall = orall | sh_mag_reg[k][l];
            end
            take = sh_big_reg[k] && (|(orall >> (NMAG_W - 1 + SH)));
            for (int l = 0; l < NLANE; l++) begin
                smag_next[l] = take ? (sh_mag_reg[k][l] >> SH) : sh_mag_reg[k][l];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sh_v_reg[k+1] <= 1'b0;
            end else if (ce) begin
                sh_v_reg[k+1] <= sh_v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                sh_mag_reg[k+1] <= smag_next;
                sh_neg_reg[k+1] <= sh_neg_reg[k];
                sh_big_reg[k+1] <= sh_big_reg[k];
            end
        end
    end

    always_comb begin
        out_valid = sh_v_reg[NSH];
        for (int l = 0; l < NLANE; l++) begin
            out_quat[l].neg = sh_neg_reg[NSH][l];
            out_quat[l].mag = sh_mag_reg[NSH][l][NMAG_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/saq_root.sv
// ----------------------------------------------------------------------------
// saq_root: quaternion norm
// Squares, two-level sum, then one restoring square-root step per stage.
// The lane records travel alongside to meet the root.
// ----------------------------------------------------------------------------
`default_nettype none

module saq_root (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         ce,
    input  wire logic                         in_valid,
    input  wire saq_pkg::quat_t               in_quat,
    output logic                              out_valid,
    output saq_pkg::quat_t                    out_quat,
    output logic [saq_pkg::ROOT_W-1:0]        out_root
);
    import saq_pkg::*;

    localparam int NSQ = ROOT_W;

    logic            va_reg, vb_reg;
    logic [SQ_W-1:0] sq_reg [NLANE];
    logic [SQ_W:0]   s01_reg, s23_reg;
    quat_t           qa_reg, qb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (ce) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int l = 0; l < NLANE; l++) begin
                sq_reg[l] <= SQ_W'(in_quat[l].mag) * SQ_W'(in_quat[l].mag);
            end
            qa_reg  <= in_quat;
            s01_reg <= (SQ_W + 1)'(sq_reg[0]) + (SQ_W + 1)'(sq_reg[1]);
            s23_reg <= (SQ_W + 1)'(sq_reg[2]) + (SQ_W + 1)'(sq_reg[3]);
            qb_reg  <= qa_reg;
        end
    end

    // index 0: full sum, empty root
    logic [SUM_W-1:0] rem_reg [NSQ+1];
    logic [SUM_W-1:0] res_reg [NSQ+1];
    quat_t            qs_reg  [NSQ+1];
    logic             vs_reg  [NSQ+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg[0] <= 1'b0;
        end else if (ce) begin
            vs_reg[0] <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= SUM_W'(s01_reg) + SUM_W'(s23_reg);
            res_reg[0] <= '0;
            qs_reg[0]  <= qb_reg;
        end
    end

    for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (NSQ - 1 - i));
        logic [SUM_W-1:0] trial;
        logic [SUM_W-1:0] rem_next, res_next;

        always_comb begin
            trial = res_reg[i] + BIT;
            if (rem_reg[i] >= trial) begin
                rem_next = rem_reg[i] - trial;
                res_next = (res_reg[i] >> 1) + BIT;
            end else begin
                rem_next = rem_reg[i];
                res_next = res_reg[i] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vs_reg[i+1] <= 1'b0;
            end else if (ce) begin
                vs_reg[i+1] <= vs_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i+1] <= rem_next;
                res_reg[i+1] <= res_next;
                qs_reg[i+1]  <= qs_reg[i];
            end
        end
    end

    assign out_valid = vs_reg[NSQ];
    assign out_quat  = qs_reg[NSQ];
    assign out_root  = res_reg[NSQ][ROOT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/saq_div.sv
// ----------------------------------------------------------------------------
// saq_div: one component divided by the norm
// Rounded numerator, overflow check, one restoring quotient bit per stage,
// then clamp and sign, with a zero result for a zero norm.
// ----------------------------------------------------------------------------
`default_nettype none

module saq_div #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               ce,
    input  wire logic                               in_valid,
    input  wire saq_pkg::lane_t                     in_lane,
    input  wire logic [saq_pkg::ROOT_W-1:0]         in_root,
    output logic                                    out_valid,
    output logic signed [saq_pkg::DATA_W-1:0]       out_q
);
    import saq_pkg::*;

    localparam int NUMW = NMAG_W + FRAC_BITS + 1;
    localparam int CW   = ((NUMW > ROOT_W + QUO_W) ? NUMW : ROOT_W + QUO_W) + 1;
    localparam logic [QUO_W-1:0] CAP_POS =
        QUO_W'((FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS));
    localparam logic [QUO_W-1:0] CAP_NEG =
        QUO_W'((FRAC_BITS >= 15) ? 32768 : (1 << FRAC_BITS));

    logic [NUMW-1:0] num_next;
    logic            sat_next;

    always_comb begin
        num_next = (NUMW'(in_lane.mag) << FRAC_BITS) + NUMW'(in_root >> 1);
        sat_next = CW'(num_next) >= (CW'(in_root) << QUO_W);
    end

    // index 0 holds the initial partial remainder
    logic [ROOT_W-1:0] rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]  lo_reg   [QUO_W+1];
    logic [QUO_W-1:0]  quo_reg  [QUO_W+1];
    logic [ROOT_W-1:0] root_reg [QUO_W+1];
    logic              neg_reg  [QUO_W+1];
    logic              sat_reg  [QUO_W+1];
    logic              zero_reg [QUO_W+1];
    logic              v_reg    [QUO_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (ce) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= ROOT_W'(num_next >> QUO_W);
            lo_reg[0]   <= num_next[QUO_W-1:0];
            quo_reg[0]  <= '0;
            root_reg[0] <= in_root;
            neg_reg[0]  <= in_lane.neg;
            sat_reg[0]  <= sat_next;
            zero_reg[0] <= in_root == '0;
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        logic [ROOT_W:0]   trial;
        logic              ge;
        logic [ROOT_W-1:0] rem_next;

        always_comb begin
            trial    = {rem_reg[j], lo_reg[j][QUO_W-1-j]};
            ge       = trial >= {1'b0, root_reg[j]};
            rem_next = ge ? ROOT_W'(trial - {1'b0, root_reg[j]}) : ROOT_W'(trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (ce) begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j+1]  <= rem_next;
                lo_reg[j+1]   <= lo_reg[j];
                quo_reg[j+1]  <= {quo_reg[j][QUO_W-2:0], ge};
                root_reg[j+1] <= root_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                sat_reg[j+1]  <= sat_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
        end
    end

    // clamp and sign
    logic [QUO_W-1:0]        m, cap, mm;
    logic [DATA_W-1:0]       r_next;
    logic                    vo_reg;
    logic signed [DATA_W-1:0] q_out_reg;

    always_comb begin
        m   = sat_reg[QUO_W] ? '1 : quo_reg[QUO_W];
        cap = neg_reg[QUO_W] ? CAP_NEG : CAP_POS;
        mm  = (m > cap) ? cap : m;
        if (zero_reg[QUO_W]) begin
            r_next = '0;
        end else if (neg_reg[QUO_W]) begin
            r_next = DATA_W'(-mm);
        end else begin
            r_next = DATA_W'(mm);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (ce) begin
            vo_reg <= v_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            q_out_reg <= r_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_q     = q_out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/saq_checker.sv
// ----------------------------------------------------------------------------
// saq_checker: port-level checks for the shortest-arc quaternion unit
// Output hold under stall, reset, stall coupling, scalar sign and x-part range.
// ----------------------------------------------------------------------------
`default_nettype none

module saq_checker #(
    parameter int FRAC_BITS = 14
) (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [saq_pkg::OUT_W-1:0] m_tdata
);
    import saq_pkg::*;

    localparam int CAP_POS = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
    localparam int CAP_NEG = (FRAC_BITS >= 15) ? 32768 : (1 << FRAC_BITS);

    logic signed [DATA_W-1:0] qx;
    assign qx = m_tdata[DATA_W +: DATA_W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (m_tready || !m_tvalid))
        else $error("input ready not tied to output stall");

    a_wpos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[DATA_W-1])
        else $error("scalar part negative");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(qx) <= CAP_POS) && (int'(qx) >= -CAP_NEG))
        else $error("x part out of range");

endmodule

bind shortest_arc_quaternion_unit saq_checker #(.FRAC_BITS(FRAC_BITS)) u_saq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire
